### rtl/wav_header_stream_parser_defines.svh
// Assertion macros used by the parser core RTL
`ifndef WAV_HEADER_STREAM_PARSER_DEFINES_SVH
`define WAV_HEADER_STREAM_PARSER_DEFINES_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset
`define WAVHP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked in the same cycle
`define WAVHP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define WAVHP_ASSERT(lbl, prop, msg)
`define WAVHP_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

### rtl/wavhp_pkg.sv
`default_nettype none

package wavhp_pkg;

	// Default upper bound on the configured file count
	localparam int MAX_FILES_DEF = 256;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NO_RIFF  = 3'd1,
		ST_NO_WAVE  = 3'd2,
		ST_NO_FMT   = 3'd3,
		ST_NOT_PCM  = 3'd4,
		ST_NOT_MONO = 3'd5,
		ST_NOT_16   = 3'd6,
		ST_NO_DATA  = 3'd7
	} status_t;

	// One result item
	typedef struct packed {
		status_t     status;
		logic [7:0]  file_number;
		logic [31:0] total_file_size;
		logic [31:0] rate_hz;
		logic [30:0] sample_count;
		logic [31:0] data_offset;
	} result_t;

endpackage

`default_nettype wire

### rtl/wavhp_in_stage.sv
`default_nettype none

module wavhp_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       restart,
	input  wire logic       advance,
	output logic            proc,
	output logic [7:0]      data_s1,
	output logic            restart_s1
);

	logic valid_s1;
	logic load;

	// Stage is free when empty or when its item is consumed this cycle
	assign load     = !valid_s1 || advance;
	assign in_stall = !load;
	assign proc     = valid_s1 && advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			data_s1    <= data_byte;
			restart_s1 <= restart;
		end
	end

endmodule

`default_nettype wire

### rtl/wavhp_core.sv
`default_nettype none

`include "wav_header_stream_parser_defines.svh"

module wavhp_core import wavhp_pkg::*; #(
	parameter int MAX_FILES = MAX_FILES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       proc,
	input  wire logic [7:0] data_s1,
	input  wire logic       restart_s1,
	input  wire logic [8:0] file_count,
	output logic            res_valid,
	output result_t         res
);

	// Header positions
	localparam logic [5:0] POS_RIFF      = 6'd3;
	localparam logic [5:0] POS_SIZE      = 6'd7;
	localparam logic [5:0] POS_WAVE      = 6'd11;
	localparam logic [5:0] POS_FMT       = 6'd15;
	localparam logic [5:0] POS_FMT_SIZE  = 6'd19;
	localparam logic [5:0] POS_FORMAT    = 6'd21;
	localparam logic [5:0] POS_CHANNELS  = 6'd23;
	localparam logic [5:0] POS_RATE      = 6'd27;
	localparam logic [5:0] POS_BITS      = 6'd35;
	localparam logic [5:0] POS_EXT_SKIP  = 6'd36;
	localparam logic [5:0] POS_DATA_1ST  = 6'd37;
	localparam logic [5:0] POS_DATA_MARK = 6'd40;
	localparam logic [5:0] POS_DATA_LAST = 6'd44;
	localparam logic [5:0] POS_BODY_SKIP = 6'd45;

	localparam logic [31:0] MARK_RIFF = 32'h4646_4952;
	localparam logic [31:0] MARK_WAVE = 32'h4556_4157;
	localparam logic [31:0] MARK_FMT  = 32'h2074_6d66;
	localparam logic [31:0] MARK_DATA = 32'h6174_6164;
	localparam logic [31:0] BASE_FMT  = 32'd16;

	localparam logic [16:0] MaxFilesW = 17'(MAX_FILES);

	logic [5:0]  pos_q, e_pos, n_pos;
	logic [31:0] word_q, e_word, n_word;
	logic [31:0] fmt_q, e_fmt, n_fmt;
	logic [31:0] skip_q, e_skip, n_skip;
	logic [31:0] bytes_q, e_bytes, n_bytes;
	logic [31:0] size_q, e_size, n_size;
	logic [31:0] rate_q, e_rate, n_rate;
	logic [8:0]  cur_q, e_cur, n_cur;
	logic        halted_q, e_halted, n_halted;

	logic        active;
	logic [31:0] skip_dec;
	logic [31:0] bytes_inc;
	logic [31:0] word;
	logic [15:0] half;
	logic        fail;
	status_t     fail_st;

	// Restart takes effect before the byte is parsed
	always_comb begin
		e_pos    = pos_q;
		e_word   = word_q;
		e_fmt    = fmt_q;
		e_skip   = skip_q;
		e_bytes  = bytes_q;
		e_size   = size_q;
		e_rate   = rate_q;
		e_cur    = cur_q;
		e_halted = halted_q;
		if (restart_s1) begin
			e_pos    = '0;
			e_word   = '0;
			e_fmt    = '0;
			e_skip   = '0;
			e_bytes  = '0;
			e_size   = '0;
			e_rate   = '0;
			e_cur    = '0;
			e_halted = 1'b0;
		end
	end

	// Parsing is off when halted, when the file count is out of range or all counted files are done
	assign active = proc && !e_halted && (file_count != 9'd0)
		&& ({8'd0, file_count} <= MaxFilesW) && (e_cur < file_count);

	assign skip_dec  = e_skip - 32'd1;
	assign bytes_inc = (e_bytes != '1) ? e_bytes + 32'd1 : e_bytes;
	assign word      = {data_s1, e_word[31:8]};
	assign half      = word[31:16];

	// Next state and result for the byte in the input register
	always_comb begin
		n_pos     = e_pos;
		n_word    = e_word;
		n_fmt     = e_fmt;
		n_skip    = e_skip;
		n_bytes   = e_bytes;
		n_size    = e_size;
		n_rate    = e_rate;
		n_cur     = e_cur;
		n_halted  = e_halted;
		fail      = 1'b0;
		fail_st   = ST_OK;
		res_valid = 1'b0;
		res.status          = ST_OK;
		res.file_number     = e_cur[7:0];
		res.total_file_size = e_size;
		res.rate_hz         = e_rate;
		res.sample_count    = '0;
		res.data_offset     = '0;

		if (active) begin
			if (e_pos == POS_BODY_SKIP) begin
				// skip the file body; last byte starts a new file
				n_skip = skip_dec;
				if (skip_dec == '0) begin
					n_pos   = '0;
					n_word  = '0;
					n_fmt   = '0;
					n_bytes = '0;
					n_size  = '0;
					n_rate  = '0;
				end
			end else if (e_pos == POS_EXT_SKIP) begin
				n_bytes = bytes_inc;
				n_skip  = skip_dec;
				if (skip_dec == '0) begin
					n_pos = POS_DATA_1ST;
				end
			end else begin
				n_bytes = bytes_inc;
				n_word  = word;
				n_pos   = e_pos + 6'd1;
				case (e_pos)
					POS_RIFF: begin
						if (word != MARK_RIFF) begin
							fail    = 1'b1;
							fail_st = ST_NO_RIFF;
						end
					end
					POS_SIZE: begin
						n_size = word + 32'd8;
					end
					POS_WAVE: begin
						if (word != MARK_WAVE) begin
							fail    = 1'b1;
							fail_st = ST_NO_WAVE;
						end
					end
					POS_FMT: begin
						if (word != MARK_FMT) begin
							fail    = 1'b1;
							fail_st = ST_NO_FMT;
						end
					end
					POS_FMT_SIZE: begin
						n_fmt = word;
					end
					POS_FORMAT: begin
						if (half != 16'd1) begin
							fail    = 1'b1;
							fail_st = ST_NOT_PCM;
						end
					end
					POS_CHANNELS: begin
						if (half != 16'd1) begin
							fail    = 1'b1;
							fail_st = ST_NOT_MONO;
						end
					end
					POS_RATE: begin
						n_rate = word;
					end
					POS_BITS: begin
						if (half != 16'd16) begin
							fail    = 1'b1;
							fail_st = ST_NOT_16;
						end else if (e_fmt > BASE_FMT) begin
							n_skip = e_fmt - BASE_FMT;
							n_pos  = POS_EXT_SKIP;
						end else begin
							n_pos = POS_DATA_1ST;
						end
					end
					POS_DATA_MARK: begin
						if (word != MARK_DATA) begin
							fail    = 1'b1;
							fail_st = ST_NO_DATA;
						end
					end
					POS_DATA_LAST: begin
						// header complete: report and plan the body skip
						res_valid        = 1'b1;
						res.sample_count = word[31:1];
						res.data_offset  = bytes_inc;
						n_cur            = e_cur + 9'd1;
						if (n_cur >= file_count) begin
							n_halted = 1'b1;
						end
						if (e_size > bytes_inc) begin
							n_skip = e_size - bytes_inc;
							n_pos  = POS_BODY_SKIP;
						end else begin
							n_pos   = '0;
							n_word  = '0;
							n_fmt   = '0;
							n_skip  = '0;
							n_bytes = '0;
							n_size  = '0;
							n_rate  = '0;
						end
					end
					default: begin
					end
				endcase
				if (fail) begin
					res_valid  = 1'b1;
					res.status = fail_st;
					n_pos      = e_pos;
					n_halted   = 1'b1;
				end
			end
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			word_q   <= '0;
			fmt_q    <= '0;
			skip_q   <= '0;
			bytes_q  <= '0;
			size_q   <= '0;
			rate_q   <= '0;
			cur_q    <= '0;
			halted_q <= 1'b0;
		end else if (proc) begin
			pos_q    <= n_pos;
			word_q   <= n_word;
			fmt_q    <= n_fmt;
			skip_q   <= n_skip;
			bytes_q  <= n_bytes;
			size_q   <= n_size;
			rate_q   <= n_rate;
			cur_q    <= n_cur;
			halted_q <= n_halted;
		end
	end

	`WAVHP_ASSERT(a_pos_range, pos_q <= POS_BODY_SKIP, "header position out of range")
	`WAVHP_ASSERT_IMP(a_halt_quiet, halted_q && !restart_s1, !res_valid,
		"result while halted")
	`WAVHP_ASSERT_IMP(a_ok_at_end, res_valid && res.status == ST_OK,
		proc && e_pos == POS_DATA_LAST, "ok result away from end of header")

endmodule

`default_nettype wire

### rtl/wavhp_out_stage.sv
`default_nettype none

module wavhp_out_stage import wavhp_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    res_valid,
	input  wire result_t res,
	output logic         advance,
	output logic         out_valid,
	input  wire logic    out_stall,
	output result_t      out_res
);

	logic    valid_q;
	result_t res_q;

	// Slot can take a new result unless a held one is stalled
	assign advance   = !(valid_q && out_stall);
	assign out_valid = valid_q;
	assign out_res   = res_q;

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

### rtl/wav_header_stream_parser.sv
// Channel   Dir  Handshake             Payload
// in        in   in_valid / in_stall   data_byte, restart
// out       out  out_valid / out_stall status, file_number, total_file_size,
//                                      rate_hz, sample_count, data_offset
// cfg       in   cfg_valid / cfg_ready file_count
//
// One byte per cycle unless stalled: input register, parse logic, result register.
// Each byte's result is registered in the result register after the parse logic.
// The per-byte parse state update (32-bit add, compare and subtract) sets the clock.
// Reset is asynchronous, active low; file_count resets to 1.
// A stalled result holds the input register, which then stalls the input.
`default_nettype none

module wav_header_stream_parser import wavhp_pkg::*; #(
	parameter int MAX_FILES = MAX_FILES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        restart,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [7:0]       file_number,
	output logic [31:0]      total_file_size,
	output logic [31:0]      rate_hz,
	output logic [30:0]      sample_count,
	output logic [31:0]      data_offset,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [8:0]  file_count
);

	logic       advance;
	logic       proc;
	logic [7:0] data_s1;
	logic       restart_s1;
	logic       res_valid;
	result_t    res;
	result_t    out_res;
	logic [8:0] file_count_q;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_count_q <= 9'd1;
		end else if (cfg_valid && cfg_ready) begin
			file_count_q <= file_count;
		end
	end

	wavhp_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.restart    (restart),
		.advance    (advance),
		.proc       (proc),
		.data_s1    (data_s1),
		.restart_s1 (restart_s1)
	);

	wavhp_core #(
		.MAX_FILES (MAX_FILES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.proc       (proc),
		.data_s1    (data_s1),
		.restart_s1 (restart_s1),
		.file_count (file_count_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	wavhp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	// Result fields to ports
	assign status          = out_res.status;
	assign file_number     = out_res.file_number;
	assign total_file_size = out_res.total_file_size;
	assign rate_hz         = out_res.rate_hz;
	assign sample_count    = out_res.sample_count;
	assign data_offset     = out_res.data_offset;

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import wavhp_pkg::*;

	// Chunk markers as little-endian words
	localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
	localparam logic [31:0] WAVE_TAG = 32'h4556_4157;
	localparam logic [31:0] FMT_TAG = 32'h2074_6d66;
	localparam logic [31:0] DATA_TAG = 32'h6174_6164;
	localparam logic [31:0] BASE_FMT_LEN = 32'd16;

	// Header positions where a word is complete or the parse changes mode
	localparam logic [5:0] HP_RIFF_END = 6'd3;
	localparam logic [5:0] HP_SIZE_END = 6'd7;
	localparam logic [5:0] HP_WAVE_END = 6'd11;
	localparam logic [5:0] HP_FMT_END = 6'd15;
	localparam logic [5:0] HP_FMTLEN_END = 6'd19;
	localparam logic [5:0] HP_FORMAT_END = 6'd21;
	localparam logic [5:0] HP_CHANNELS_END = 6'd23;
	localparam logic [5:0] HP_RATE_END = 6'd27;
	localparam logic [5:0] HP_BITS_END = 6'd35;
	localparam logic [5:0] HP_EXT_SKIP = 6'd36;
	localparam logic [5:0] HP_DATA_FIRST = 6'd37;
	localparam logic [5:0] HP_DATA_TAG_END = 6'd40;
	localparam logic [5:0] HP_DATA_LAST = 6'd44;
	localparam logic [5:0] HP_BODY_SKIP = 6'd45;

	// File counts for the first random phases: extremes, ordinary and illegal values
	localparam logic [8:0] COUNT_PLAN [8] = '{9'd256, 9'd1, 9'd2, 9'd5, 9'd0, 9'd300, 9'd511, 9'd3};

	// Header parse predictor and queue of expected header results
	class header_scoreboard;
		logic [8:0] file_limit;
		logic [5:0] hdr_pos;
		logic [31:0] word_acc;
		logic [31:0] fmt_len;
		logic [31:0] skip_left;
		logic [31:0] file_bytes;
		logic [31:0] size_total;
		logic [31:0] rate;
		logic [8:0] file_idx;
		bit stopped;
		result_t expected_headers[$];
		int errors;

		function new();
			file_limit = 9'd1;
			file_idx = '0;
			stopped = 0;
			errors = 0;
			start_file();
		endfunction

		function void start_file();
			hdr_pos = '0;
			word_acc = '0;
			fmt_len = '0;
			skip_left = '0;
			file_bytes = '0;
			size_total = '0;
			rate = '0;
		endfunction

		function void set_file_limit(logic [8:0] v);
			file_limit = v;
		endfunction

		function void push_header(status_t st, logic [30:0] count, logic [31:0] offset);
			result_t r;
			r.status = st;
			r.file_number = file_idx[7:0];
			r.total_file_size = size_total;
			r.rate_hz = rate;
			r.sample_count = count;
			r.data_offset = offset;
			expected_headers.push_back(r);
		endfunction

		// Error result: counts and offset are zero, parse stops
		function void abort(status_t st);
			stopped = 1;
			push_header(st, '0, '0);
		endfunction

		// Returns 1 when the byte took part in the parse, 0 when it was ignored
		function bit note_byte(logic [7:0] b, logic r);
			logic [15:0] half;
			if (r) begin
				file_idx = '0;
				stopped = 0;
				start_file();
			end
			if (stopped || file_limit == 0 || file_limit > MAX_FILES_DEF || file_idx >= file_limit)
				return 0;
			if (hdr_pos == HP_BODY_SKIP) begin
				skip_left--;
				if (skip_left == 0)
					start_file();
				return 1;
			end
			if (file_bytes != '1)
				file_bytes++;
			if (hdr_pos == HP_EXT_SKIP) begin
				skip_left--;
				if (skip_left == 0)
					hdr_pos = HP_DATA_FIRST;
				return 1;
			end
			word_acc = {b, word_acc[31:8]};
			half = word_acc[31:16];
			case (hdr_pos)
				HP_RIFF_END: if (word_acc != RIFF_TAG) begin
					abort(ST_NO_RIFF);
					return 1;
				end
				HP_SIZE_END: size_total = word_acc + 32'd8;
				HP_WAVE_END: if (word_acc != WAVE_TAG) begin
					abort(ST_NO_WAVE);
					return 1;
				end
				HP_FMT_END: if (word_acc != FMT_TAG) begin
					abort(ST_NO_FMT);
					return 1;
				end
				HP_FMTLEN_END: fmt_len = word_acc;
				HP_FORMAT_END: if (half != 16'd1) begin
					abort(ST_NOT_PCM);
					return 1;
				end
				HP_CHANNELS_END: if (half != 16'd1) begin
					abort(ST_NOT_MONO);
					return 1;
				end
				HP_RATE_END: rate = word_acc;
				HP_BITS_END: begin
					if (half != 16'd16) begin
						abort(ST_NOT_16);
						return 1;
					end
					// fmt extension gets skipped before the data chunk
					if (fmt_len > BASE_FMT_LEN) begin
						skip_left = fmt_len - BASE_FMT_LEN;
						hdr_pos = HP_EXT_SKIP;
					end else begin
						hdr_pos = HP_DATA_FIRST;
					end
					return 1;
				end
				HP_DATA_TAG_END: if (word_acc != DATA_TAG) begin
					abort(ST_NO_DATA);
					return 1;
				end
				HP_DATA_LAST: begin
					push_header(ST_OK, word_acc[31:1], file_bytes);
					file_idx++;
					if (file_idx >= file_limit)
						stopped = 1;
					// short file: next byte already starts the next file
					if (size_total > file_bytes) begin
						skip_left = size_total - file_bytes;
						hdr_pos = HP_BODY_SKIP;
					end else begin
						start_file();
					end
					return 1;
				end
				default: ;
			endcase
			hdr_pos++;
			return 1;
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_headers.size() == 0) begin
				$error("unexpected result: status %0d file %0d", got.status, got.file_number);
				errors++;
				return;
			end
			want = expected_headers.pop_front();
			if (got.status != want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.file_number != want.file_number) begin
				$error("file_number: expected %0d, got %0d", want.file_number, got.file_number);
				errors++;
			end
			if (got.total_file_size != want.total_file_size) begin
				$error("total_file_size: expected %h, got %h", want.total_file_size,
					got.total_file_size);
				errors++;
			end
			if (got.rate_hz != want.rate_hz) begin
				$error("rate_hz: expected %h, got %h", want.rate_hz, got.rate_hz);
				errors++;
			end
			if (got.sample_count != want.sample_count) begin
				$error("sample_count: expected %h, got %h", want.sample_count, got.sample_count);
				errors++;
			end
			if (got.data_offset != want.data_offset) begin
				$error("data_offset: expected %h, got %h", want.data_offset, got.data_offset);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] data_byte;
	logic restart;
	logic out_valid;
	logic out_stall;
	logic [2:0] status;
	logic [7:0] file_number;
	logic [31:0] total_file_size;
	logic [31:0] rate_hz;
	logic [30:0] sample_count;
	logic [31:0] data_offset;
	logic cfg_valid;
	logic cfg_ready;
	logic [8:0] file_count;

	header_scoreboard sb = new();
	logic [7:0] image_bytes[$];
	int sent_bytes;
	bit idle_on;
	bit hold_req;

	wav_header_stream_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.file_number(file_number),
		.total_file_size(total_file_size),
		.rate_hz(rate_hz),
		.sample_count(sample_count),
		.data_offset(data_offset),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.file_count(file_count)
	);

	always #4 clk = ~clk;

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({status, file_number, total_file_size, rate_hz, sample_count,
				data_offset});
	end

	// Result side: random stall bursts, plus one long hold to back up the input
	initial begin
		out_stall = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_stall <= 1;
				repeat (300) @(posedge clk);
				out_stall <= 0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_stall <= 1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("testbench: errors");
		$finish;
	end

	// Little-endian append of n bytes
	function void put_word(logic [31:0] w, int n);
		for (int i = 0; i < n; i++)
			image_bytes.push_back(w[8*i +: 8]);
	endfunction

	// One WAV file; a fault code breaks the field that triggers that status
	function void add_file(logic [31:0] total, logic [31:0] fmt_field, logic [31:0] rate,
		logic [31:0] data_size, int body_len, status_t fault);
		int base;
		int ext;
		int spot;
		base = image_bytes.size();
		ext = (fmt_field > BASE_FMT_LEN) ? int'(fmt_field - BASE_FMT_LEN) : 0;
		put_word(RIFF_TAG, 4);
		put_word(total - 32'd8, 4);
		put_word(WAVE_TAG, 4);
		put_word(FMT_TAG, 4);
		put_word(fmt_field, 4);
		put_word(32'd1, 2);
		put_word(32'd1, 2);
		put_word(rate, 4);
		put_word($urandom, 4);
		put_word($urandom, 2);
		put_word(32'd16, 2);
		for (int i = 0; i < ext; i++)
			put_word($urandom, 1);
		put_word(DATA_TAG, 4);
		put_word(data_size, 4);
		for (int i = 0; i < body_len; i++)
			put_word($urandom, 1);
		case (fault)
			ST_NO_RIFF: spot = $urandom_range(0, 3);
			ST_NO_WAVE: spot = $urandom_range(8, 11);
			ST_NO_FMT: spot = $urandom_range(12, 15);
			ST_NOT_PCM: spot = $urandom_range(20, 21);
			ST_NOT_MONO: spot = $urandom_range(22, 23);
			ST_NOT_16: spot = $urandom_range(34, 35);
			ST_NO_DATA: spot = $urandom_range(36 + ext, 39 + ext);
			default: spot = -1;
		endcase
		if (spot >= 0)
			image_bytes[base + spot] ^= 8'(1 << $urandom_range(0, 7));
	endfunction

	// Random file; returns 1 when it was broken, so later files go unparsed
	function bit add_random_file(bit allow_fault, bit allow_long);
		int ext;
		int header;
		int body;
		logic [31:0] fmt_field;
		logic [31:0] total;
		logic [31:0] rate;
		status_t fault;
		ext = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		fmt_field = 32'(16 + ext);
		if (ext == 0 && $urandom_range(0, 4) == 0)
			fmt_field = $urandom_range(0, 15);
		header = 44 + ext;
		case ($urandom_range(0, 7))
			0: rate = '0;
			1: rate = '1;
			default: rate = $urandom;
		endcase
		if (allow_long && $urandom_range(0, 9) == 0) begin
			// body far longer than what gets sent; the next image restarts
			total = $urandom | 32'h1000_0000;
			body = $urandom_range(0, 8);
		end else if ($urandom_range(0, 7) == 0) begin
			total = $urandom_range(0, header);
			body = 0;
		end else begin
			body = $urandom_range(1, 16);
			total = 32'(header + body);
		end
		fault = ST_OK;
		if (allow_fault && $urandom_range(0, 5) == 0)
			fault = status_t'($urandom_range(1, 7));
		add_file(total, fmt_field, rate, $urandom, body, fault);
		return fault != ST_OK;
	endfunction

	// One byte transfer, with an optional idle burst ahead of it
	task send_byte(logic [7:0] b, logic r);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1;
		data_byte <= b;
		restart <= r;
		do @(posedge clk); while (in_stall);
		void'(sb.note_byte(b, r));
		sent_bytes++;
	endtask

	task send_image(bit fresh);
		foreach (image_bytes[i])
			send_byte(image_bytes[i], fresh && i == 0);
		image_bytes.delete();
	endtask

	task send_noise();
		int n;
		n = $urandom_range(8, 40);
		for (int i = 0; i < n; i++)
			send_byte(8'($urandom), i == 0 || $urandom_range(0, 15) == 0);
	endtask

	// Register write once the parser has drained
	task write_count(logic [8:0] v);
		in_valid <= 0;
		while (sb.expected_headers.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		cfg_valid <= 1;
		file_count <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.set_file_limit(v);
	endtask

	// Count lowered below the files done, then raised: parse resumes mid-image
	task count_drop();
		write_count(9'd4);
		repeat (3) void'(add_random_file(0, 0));
		send_image(1);
		write_count(9'd2);
		void'(add_random_file(0, 0));
		send_image(0);
		write_count(9'd8);
		repeat (2) void'(add_random_file(0, 0));
		send_image(0);
	endtask

	initial begin
		int phase;
		int nfiles;
		int cut;
		bit held;
		logic [8:0] cnt;
		clk = 0;
		arst_n = 0;
		in_valid = 0;
		data_byte = '0;
		restart = 0;
		cfg_valid = 0;
		file_count = 9'd1;
		idle_on = 1;
		hold_req = 0;
		sent_bytes = 0;
		held = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: all-ones fields with size equal to header, then every error
		add_file(32'd44, 32'd16, '1, '1, 0, ST_OK);
		send_image(1);
		for (int f = ST_NO_RIFF; f <= ST_NO_DATA; f++) begin
			add_file(32'd60, 32'd20, $urandom, $urandom, 12, status_t'(f));
			send_image(1);
		end
		// Extension skip, zero RIFF size wrapping to 0, then past the count
		write_count(9'd3);
		add_file(32'd52, 32'd21, 32'd48000, 32'd100, 3, ST_OK);
		add_file(32'd0, 32'd0, '0, '0, 0, ST_OK);
		add_file(32'd46, 32'd16, 32'd22050, 32'd7, 2, ST_OK);
		add_file(32'd50, 32'd16, 32'd8000, 32'd9, 6, ST_OK);
		send_image(1);

		// Random phases
		phase = 0;
		while (sent_bytes < 1700) begin
			if (phase < 8)
				cnt = COUNT_PLAN[phase];
			else if ($urandom_range(0, 9) == 0)
				cnt = 9'($urandom_range(0, 511));
			else
				cnt = 9'($urandom_range(1, 6));
			idle_on = (sent_bytes < 1450) && ($urandom_range(0, 3) != 0);
			if (phase % 6 == 5) begin
				count_drop();
			end else begin
				write_count(cnt);
				if (cnt == 9'd256 && !held) begin
					held = 1;
					idle_on = 1;
					hold_req = 1;
				end
				repeat ($urandom_range(1, 3)) begin
					// the long hold gets whole files so results back up
					case (hold_req ? 2 : $urandom_range(0, 9))
						0: send_noise();
						1: begin
							void'(add_random_file(0, 0));
							cut = $urandom_range(1, image_bytes.size() - 1);
							repeat (cut) void'(image_bytes.pop_back());
							send_image(1);
						end
						default: begin
							nfiles = $urandom_range(1, 5);
							for (int k = 0; k < nfiles; k++)
								if (add_random_file(1, k == nfiles - 1))
									break;
							send_image(1);
						end
					endcase
				end
			end
			phase++;
		end

		// Drain
		in_valid <= 0;
		while (sb.expected_headers.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
